[sv/oahm_pkg.sv]
package oahm_pkg;

    localparam int SLOTS  = 256;
    localparam int ADDR_W = $clog2(SLOTS);
    localparam int CNT_W  = 9;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_FULL     = 2'd1;
    localparam logic [1:0] STS_ZERO_KEY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_CHK,
        ST_ZERO
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;    // latch the input beat, start at home slot
        logic step;    // advance to next probe slot
        logic finish;  // commit table update and load the result beat
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic key_zero;
        logic resolved;  // key found or empty slot reached
        logic last;      // final probe of the sequence
        logic out_free;  // result register can take a beat this cycle
    } t_sts;

endpackage

[sv/open_address_hash_map.sv]
// Open-addressing key/value map, 256 slots, 32-bit keys and values.
// Input channel: i_valid / o_stall with i_cmd (0 lookup, 1 insert), i_key, i_value.
//   A beat is taken when i_valid is high and o_stall is low; o_stall is low
//   only while the block is idle, so one item is worked at a time.
// Output channel: o_valid / i_stall with o_read_value, o_hit, o_status,
//   o_entry_count; one result beat per input beat, in order.
// Probing starts at key & 255 and steps pos = 5*pos + 1 (mod 256) until the
//   key or an empty slot is found, at most 256 probes.
// Each probe takes a read step (address the RAMs) and a check step (compare the
//   registered key RAM read). The result is registered when the check step
//   finishes, and the next item can be taken once the block is back in idle.
//   A zero key skips probing and is answered from its own zero-key step.
// The result sits in an output register; the next item is accepted while it
//   waits. If the receiver stalls, a finished item holds in its check or zero-key
//   step (no table update yet) until the register frees.
// Reset (synchronous, active low) clears the per-slot valid bits, entry
//   count and output valid at once; no clearing pass is needed.
module open_address_hash_map (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_cmd,
    input  logic [oahm_pkg::KEY_W-1:0] i_key,
    input  logic [oahm_pkg::VAL_W-1:0] i_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [oahm_pkg::VAL_W-1:0] o_read_value,
    output logic                       o_hit,
    output logic [1:0]                 o_status,
    output logic [oahm_pkg::CNT_W-1:0] o_entry_count
);
    import oahm_pkg::*;

    t_ctl ctl;
    t_sts sts;

    // sequencer: idle / read / check / zero-key
    oahm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // key/value RAMs, slot valid bits, probe pointer and result register
    oahm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (i_cmd),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_stall       (i_stall),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_read_value  (o_read_value),
        .o_hit         (o_hit),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

[sv/oahm_ram.sv]
module oahm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/oahm_ctrl.sv]
module oahm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  oahm_pkg::t_sts i_sts,
    output oahm_pkg::t_ctl o_ctl
);
    import oahm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_sts.key_zero ? ST_ZERO : ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (i_sts.resolved || i_sts.last) begin
                    if (i_sts.out_free) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_ZERO: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall    = 1'b0;
                o_ctl.load = i_valid;
            end
            ST_RD: begin
            end
            ST_CHK: begin
                if (i_sts.resolved || i_sts.last) begin
                    o_ctl.finish = i_sts.out_free;
                end else begin
                    o_ctl.step = 1'b1;
                end
            end
            ST_ZERO: begin
                o_ctl.finish = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/oahm_dp.sv]
module oahm_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd,
    input  logic [oahm_pkg::KEY_W-1:0] i_key,
    input  logic [oahm_pkg::VAL_W-1:0] i_value,
    input  logic                       i_stall,
    input  oahm_pkg::t_ctl             i_ctl,
    output oahm_pkg::t_sts             o_sts,
    output logic                       o_valid,
    output logic [oahm_pkg::VAL_W-1:0] o_read_value,
    output logic                       o_hit,
    output logic [1:0]                 o_status,
    output logic [oahm_pkg::CNT_W-1:0] o_entry_count
);
    import oahm_pkg::*;

    logic              r_cmd;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [ADDR_W-1:0] r_pos;
    logic [ADDR_W-1:0] n_pos;
    logic [ADDR_W-1:0] r_probe;
    logic [SLOTS-1:0]  r_valid;
    logic [CNT_W-1:0]  r_count;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_value;
    logic              r_out_hit;
    logic [1:0]        r_out_status;

    logic [KEY_W-1:0]  key_rdata;
    logic [VAL_W-1:0]  val_rdata;
    logic              slot_used;
    logic              match;
    logic              empty;
    logic              key_we;
    logic              val_we;

    // both arrays read at the current probe slot every cycle
    oahm_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (r_pos),
        .o_rdata (key_rdata)
    );

    oahm_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS)) u_values (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (r_pos),
        .i_wdata (r_value),
        .i_raddr (r_pos),
        .o_rdata (val_rdata)
    );

    assign slot_used = r_valid[r_pos];
    assign match     = slot_used && (key_rdata == r_key);
    assign empty     = !slot_used;
    assign n_pos     = r_pos + (r_pos << 2) + ADDR_W'(1);

    // table writes only on an insert that resolved to a slot
    assign val_we = i_ctl.finish && (r_key != '0) && (r_cmd == CMD_INSERT) && (match || empty);
    assign key_we = val_we && empty;

    assign o_sts.key_zero = (i_key == '0);
    assign o_sts.resolved = match || empty;
    assign o_sts.last     = (r_probe == '1);
    assign o_sts.out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd   <= i_cmd;
            r_key   <= i_key;
            r_value <= i_value;
            r_pos   <= i_key[ADDR_W-1:0];
            r_probe <= '0;
        end else if (i_ctl.step) begin
            r_pos   <= n_pos;
            r_probe <= r_probe + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (key_we) begin
                r_valid[r_pos] <= 1'b1;
                r_count        <= r_count + CNT_W'(1);
            end
            if (i_ctl.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_out_value  <= '0;
            r_out_hit    <= 1'b0;
            r_out_status <= STS_OK;
            if (r_key == '0) begin
                r_out_status <= STS_ZERO_KEY;
            end else if (match) begin
                r_out_hit <= 1'b1;
                if (r_cmd == CMD_LOOKUP) begin
                    r_out_value <= val_rdata;
                end
            end else if (!empty && (r_cmd == CMD_INSERT)) begin
                r_out_status <= STS_FULL;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_hit         = r_out_hit;
    assign o_status      = r_out_status;
    // count register already reflects this beat's insert on the same edge
    assign o_entry_count = r_count;

endmodule
